/* hdl/bam_pkg.sv */
// Shared constants and types for the block average mosaic.
`default_nettype none

package bam_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

  localparam int unsigned RST_FRAME_WIDTH  = 512;
  localparam int unsigned RST_FRAME_HEIGHT = 512;
  localparam int unsigned RST_BLOCK_SIZE   = 8;

  localparam int unsigned HEIGHT_LIMIT = 512;
  localparam int unsigned ROW_W        = 9;
  localparam int unsigned AVG_OUT_W    = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [8:0] block_row;
    logic [8:0] block_col;
    logic       frame_last;
  } bam_pos_t;

endpackage

`default_nettype wire

/* hdl/bam_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bam_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 512,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/bam_queue.sv */
// Small register FIFO between the pixel front end and the divider.
`default_nettype none

module bam_queue #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue popped while empty");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push == pop) |=> $stable(count_r))
    else $error("queue fill changed without a lone push or pop");

endmodule

`default_nettype wire

/* hdl/bam_front.sv */
// Pixel front end: config, raster counters, per-column block sums, block completion.
`default_nettype none

module bam_front
  import bam_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned MAX_BLOCK  = 16,
  localparam int unsigned LB    = $clog2(MAX_BLOCK),
  localparam int unsigned SUM_W = PIXEL_BITS + 2 * LB,
  localparam int unsigned REM_W = 2 * LB + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] in_pixel,
  output logic                       push,
  output logic      [SUM_W-1:0]      push_sum,
  output bam_pos_t                   push_pos,
  input  wire logic                  q_full,
  output logic      [REM_W-1:0]      b_sq
);

  localparam int unsigned W_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned B_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned H_W = CFG_DATA_W;
  localparam int unsigned XW  = $clog2(MAX_WIDTH + 2 * MAX_BLOCK + 1) + 1;
  localparam int unsigned YW  = $clog2(HEIGHT_LIMIT + 2 * MAX_BLOCK + 1) + 1;

  localparam int unsigned RST_W_V = (MAX_WIDTH < RST_FRAME_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int unsigned RST_B_V = (MAX_BLOCK < RST_BLOCK_SIZE) ? MAX_BLOCK : RST_BLOCK_SIZE;

  // clamped configuration
  logic [W_W-1:0]   w_r;
  logic [H_W-1:0]   h_r;
  logic [B_W-1:0]   b_r;
  logic [REM_W-1:0] bsq_r;
  logic [W_W-1:0]   w_wr;
  logic [H_W-1:0]   h_wr;
  logic [B_W-1:0]   b_wr;

  // raster position
  logic [CW-1:0]    col_r, col_nxt;
  logic [B_W-1:0]   cib_r, cib_nxt;
  logic [CW-1:0]    bc_r, bc_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [B_W-1:0]   rib_r, rib_nxt;
  logic [ROW_W-1:0] brow_r, brow_nxt;

  logic [SUM_W-1:0] seg_r;
  logic [SUM_W-1:0] seg_cur;
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] ram_rd_data;

  logic [XW-1:0] col_base;
  logic [YW-1:0] row_base;
  logic accept, first_c, last_c, last_r, row_end, frame_end;
  logic full_col, full_row, last_col, last_row, in_block;

  always_comb begin
    if (cfg_wdata == '0) begin
      w_wr = W_W'(1);
    end else if (32'(cfg_wdata) > MAX_WIDTH) begin
      w_wr = W_W'(MAX_WIDTH);
    end else begin
      w_wr = W_W'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      h_wr = H_W'(1);
    end else if (32'(cfg_wdata) > HEIGHT_LIMIT) begin
      h_wr = H_W'(HEIGHT_LIMIT);
    end else begin
      h_wr = cfg_wdata;
    end
    if (cfg_wdata[4:0] == '0) begin
      b_wr = B_W'(1);
    end else if (32'(cfg_wdata[4:0]) > MAX_BLOCK) begin
      b_wr = B_W'(MAX_BLOCK);
    end else begin
      b_wr = B_W'(cfg_wdata[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= W_W'(RST_W_V);
      h_r   <= H_W'(RST_FRAME_HEIGHT);
      b_r   <= B_W'(RST_B_V);
      bsq_r <= REM_W'(RST_B_V * RST_B_V);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_r <= w_wr;
        REG_FRAME_HEIGHT: h_r <= h_wr;
        REG_BLOCK_SIZE: begin
          b_r   <= b_wr;
          bsq_r <= REM_W'(b_wr) * REM_W'(b_wr);
        end
        default: ;
      endcase
    end
  end

  assign b_sq     = bsq_r;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    first_c   = (cib_r == '0);
    last_c    = ({1'b0, cib_r} + 1'b1) == {1'b0, b_r};
    last_r    = ({1'b0, rib_r} + 1'b1) == {1'b0, b_r};
    row_end   = (XW'(col_r) + XW'(1)) == XW'(w_r);
    frame_end = (YW'(row_r) + YW'(1)) == YW'(h_r);

    col_base  = XW'(col_r) - XW'(cib_r);
    row_base  = YW'(row_r) - YW'(rib_r);
    full_col  = (col_base + XW'(b_r)) <= XW'(w_r);
    full_row  = (row_base + YW'(b_r)) <= YW'(h_r);
    last_col  = (col_base + XW'(b_r) + XW'(b_r)) > XW'(w_r);
    last_row  = (row_base + YW'(b_r) + YW'(b_r)) > YW'(h_r);
    in_block  = full_col && full_row;

    // first row of a block row starts from zero, so the store needs no clearing
    seg_cur = (first_c ? '0 : seg_r) + SUM_W'(in_pixel);
    old_sum = (rib_r == '0) ? '0 : ram_rd_data;
    total   = old_sum + seg_cur;
  end

  always_comb begin
    col_nxt  = col_r;
    cib_nxt  = cib_r;
    bc_nxt   = bc_r;
    row_nxt  = row_r;
    rib_nxt  = rib_r;
    brow_nxt = brow_r;
    if (accept) begin
      if (last_c) begin
        cib_nxt = '0;
        bc_nxt  = bc_r + 1'b1;
      end else begin
        cib_nxt = cib_r + 1'b1;
      end
      if (row_end) begin
        col_nxt = '0;
        cib_nxt = '0;
        bc_nxt  = '0;
        if (last_r) begin
          rib_nxt  = '0;
          brow_nxt = brow_r + 1'b1;
        end else begin
          rib_nxt = rib_r + 1'b1;
        end
        if (frame_end) begin
          row_nxt  = '0;
          rib_nxt  = '0;
          brow_nxt = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r  <= '0;
      cib_r  <= '0;
      bc_r   <= '0;
      row_r  <= '0;
      rib_r  <= '0;
      brow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      cib_r  <= cib_nxt;
      bc_r   <= bc_nxt;
      row_r  <= row_nxt;
      rib_r  <= rib_nxt;
      brow_r <= brow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg_r <= seg_cur;
    end
  end

  bam_ram #(
    .DATA_W (SUM_W),
    .DEPTH  (MAX_WIDTH)
  ) u_sums (
    .clk     (clk),
    .wr_en   (accept && last_c && in_block && !last_r),
    .wr_addr (bc_r),
    .wr_data (total),
    .rd_en   (accept && first_c),
    .rd_addr (bc_r),
    .rd_data (ram_rd_data)
  );

  assign push                = accept && last_c && last_r && in_block;
  assign push_sum            = total;
  assign push_pos.block_row  = brow_r;
  assign push_pos.block_col  = 9'(bc_r);
  assign push_pos.frame_last = last_row && last_col;

endmodule

`default_nettype wire

/* hdl/bam_div.sv */
// Back end: restoring divide of a block sum by block size squared, output register.
`default_nettype none

module bam_div
  import bam_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned MAX_BLOCK  = 16,
  localparam int unsigned LB    = $clog2(MAX_BLOCK),
  localparam int unsigned SUM_W = PIXEL_BITS + 2 * LB,
  localparam int unsigned REM_W = 2 * LB + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire logic [SUM_W-1:0]     q_sum,
  input  wire bam_pos_t             q_pos,
  input  wire logic [REM_W-1:0]     divisor,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [AVG_OUT_W-1:0] out_block_average,
  output logic      [8:0]           out_block_row,
  output logic      [8:0]           out_block_col,
  output logic                      out_frame_last
);

  localparam int unsigned STEP_W = $clog2(PIXEL_BITS + 1);
  localparam int unsigned AVG_W  = (PIXEL_BITS > AVG_OUT_W) ? PIXEL_BITS : AVG_OUT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [REM_W-1:0]      rem_r;
  logic [PIXEL_BITS-1:0] quo_r;
  bam_pos_t              pos_r;
  logic [AVG_OUT_W-1:0]  avg_r;
  bam_pos_t              opos_r;

  logic [REM_W-1:0]      trial;
  logic                  take;
  logic                  load_out;
  logic [AVG_W-1:0]      avg_ext;

  always_comb begin
    trial    = {rem_r[REM_W-2:0], quo_r[PIXEL_BITS-1]};
    take     = (trial >= divisor);
    q_pop    = (state_r == S_IDLE) && !q_empty;
    load_out = (state_r == S_HOLD) && (!out_valid_r || !out_stall);
    avg_ext  = AVG_W'(quo_r);

    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_RUN;
          step_nxt  = STEP_W'(PIXEL_BITS);
        end
      end
      S_RUN: begin
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r <= REM_W'(q_sum[SUM_W-1:PIXEL_BITS]);
      quo_r <= q_sum[PIXEL_BITS-1:0];
      pos_r <= q_pos;
    end else if (state_r == S_RUN) begin
      rem_r <= take ? (trial - divisor) : trial;
      quo_r <= PIXEL_BITS'({quo_r, take});
    end
    if (load_out) begin
      avg_r  <= avg_ext[AVG_OUT_W-1:0];
      opos_r <= pos_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_average = avg_r;
  assign out_block_row     = opos_r.block_row;
  assign out_block_col     = opos_r.block_col;
  assign out_frame_last    = opos_r.frame_last;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (rem_r < divisor))
    else $error("partial remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (divisor != '0))
    else $error("zero divisor at start of divide");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(avg_r) && $stable(opos_r)))
    else $error("stalled result beat changed");

endmodule

`default_nettype wire

/* hdl/block_average_mosaic_top.sv */
// Top level of the block average mosaic: front end, queue and divider.
//
// Pixels enter in raster order on in_valid / in_stall / in_pixel, one beat
// per pixel. When the bottom-right pixel of a full square block is taken,
// the block sum goes into a 4-entry queue; the divider takes it and returns
// floor(sum / block_size^2) with the block's row, column and a frame_last
// flag on out_valid / out_stall.
// Throughput: one pixel per cycle while the queue has room. The divider
// works on one block sum at a time, one quotient bit per cycle, so small
// block sizes that finish blocks faster than the divider drains them fill
// the queue and raise in_stall.
// A completing block sum passes through the queue, the divider's idle,
// run and hold states and the output register before out_valid.
// A stalled result sits in the output register; the divider finishes the
// next block behind it and the front end keeps taking pixels until the
// queue is full.
// Reset (rst_n low, synchronous) restores 512 x 512, block 8 and clears all
// counters. Any config write restarts the frame. The sum store needs no
// clearing pass: the first row of every block row starts its sums at zero.
`default_nettype none

module block_average_mosaic_top
  import bam_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned MAX_BLOCK  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] in_pixel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [AVG_OUT_W-1:0]  out_block_average,
  output logic      [8:0]            out_block_row,
  output logic      [8:0]            out_block_col,
  output logic                       out_frame_last
);

  localparam int unsigned LB    = $clog2(MAX_BLOCK);
  localparam int unsigned SUM_W = PIXEL_BITS + 2 * LB;
  localparam int unsigned REM_W = 2 * LB + 1;
  localparam int unsigned POS_W = $bits(bam_pos_t);
  localparam int unsigned QW    = SUM_W + POS_W;

  logic             push;
  logic [SUM_W-1:0] push_sum;
  bam_pos_t         push_pos;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  logic [SUM_W-1:0] q_sum;
  bam_pos_t         q_pos;
  logic [REM_W-1:0] b_sq;

  bam_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .push      (push),
    .push_sum  (push_sum),
    .push_pos  (push_pos),
    .q_full    (q_full),
    .b_sq      (b_sq)
  );

  bam_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_sum, push_pos}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign q_sum = q_data[QW-1 -: SUM_W];
  assign q_pos = bam_pos_t'(q_data[POS_W-1:0]);

  bam_div #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_div (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_sum             (q_sum),
    .q_pos             (q_pos),
    .divisor           (b_sq),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_block_average (out_block_average),
    .out_block_row     (out_block_row),
    .out_block_col     (out_block_col),
    .out_frame_last    (out_frame_last)
  );

endmodule

`default_nettype wire

/* tb/sv/block_average_mosaic_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the block average mosaic top level.
module block_average_mosaic_top_test
  import bam_pkg::*;
();

  localparam int unsigned MAX_W        = 512;
  localparam int unsigned MAX_B        = 16;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SHOWN_ERRORS = 10;
  localparam int unsigned PHASE_BEATS  = 80;

  // index past the register list: restarts the frame and nothing else
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int unsigned {PIX_RANDOM, PIX_WHITE, PIX_BINARY} pixel_mode_e;

  typedef struct packed {
    logic [AVG_OUT_W-1:0] average;
    bam_pos_t             pos;
  } block_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_pixel  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AVG_OUT_W-1:0]  out_block_average;
  logic [8:0]            out_block_row;
  logic [8:0]            out_block_col;
  logic                  out_frame_last;

  // mosaic predictor state
  logic [9:0]  frame_width_q;
  logic [9:0]  frame_height_q;
  logic [4:0]  block_size_q;
  logic [15:0] column_totals [MAX_W];
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned row_in_blk;
  int unsigned col_in_blk;
  int unsigned blk_col;

  block_result_t expected_blocks[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  logic        hold_off       = 1'b0;

  block_average_mosaic_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_block_average (out_block_average),
    .out_block_row     (out_block_row),
    .out_block_col     (out_block_col),
    .out_frame_last    (out_frame_last)
  );

  always #2 clk = ~clk;

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    foreach (column_totals[i]) column_totals[i] = '0;
    row_pos    = 0;
    col_pos    = 0;
    row_in_blk = 0;
    col_in_blk = 0;
    blk_col    = 0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        frame_width_q = data[9:0];
      end
      REG_FRAME_HEIGHT: begin
        frame_height_q = data[9:0];
      end
      REG_BLOCK_SIZE: begin
        block_size_q = data[4:0];
      end
      default: begin
      end
    endcase
    restart_frame();
  endfunction

  function automatic void predict_pixel(input logic [7:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned b;
    int unsigned full_cols;
    int unsigned full_rows;
    int unsigned brow;
    block_result_t blk;
    w = eff_dim(frame_width_q, MAX_W);
    h = eff_dim(frame_height_q, HEIGHT_LIMIT);
    b = eff_dim(block_size_q, MAX_B);
    full_cols = w / b;
    full_rows = h / b;
    brow = row_pos / b;
    if (blk_col < full_cols && brow < full_rows) begin
      column_totals[blk_col] = column_totals[blk_col] + px;
      if (row_in_blk + 1 >= b && col_in_blk + 1 >= b) begin
        blk.average        = AVG_OUT_W'(column_totals[blk_col] / (b * b));
        blk.pos.block_row  = brow[8:0];
        blk.pos.block_col  = blk_col[8:0];
        blk.pos.frame_last = (brow + 1 == full_rows) && (blk_col + 1 == full_cols);
        column_totals[blk_col] = '0;
        expected_blocks.push_back(blk);
      end
    end
    col_in_blk++;
    if (col_in_blk >= b) begin
      col_in_blk = 0;
      blk_col++;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos    = 0;
      col_in_blk = 0;
      blk_col    = 0;
      row_in_blk++;
      if (row_in_blk >= b) row_in_blk = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos    = 0;
        row_in_blk = 0;
      end
    end
  endfunction

  function automatic string block_text(input block_result_t blk);
    return $sformatf("avg %0d row %0d col %0d last %0b", blk.average, blk.pos.block_row,
                     blk.pos.block_col, blk.pos.frame_last);
  endfunction

  function automatic void log_mismatch(input string what, input block_result_t want,
                                       input block_result_t got);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS)
      $display("%0t %s: expected %s, got %s", $time, what, block_text(want),
               block_text(got));
  endfunction

  function automatic logic [7:0] pick_pixel(input pixel_mode_e mode);
    case (mode)
      PIX_WHITE:  return 8'hFF;
      PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  // result beats
  always @(posedge clk) begin : block_checker
    block_result_t got_blk;
    block_result_t want_blk;
    if (rst_n && out_valid && !out_stall) begin
      got_blk.average        = out_block_average;
      got_blk.pos.block_row  = out_block_row;
      got_blk.pos.block_col  = out_block_col;
      got_blk.pos.frame_last = out_frame_last;
      if (expected_blocks.size() == 0) begin
        log_mismatch("unexpected block", '0, got_blk);
      end else begin
        want_blk = expected_blocks.pop_front();
        if (got_blk.average !== want_blk.average ||
            got_blk.pos.block_row !== want_blk.pos.block_row ||
            got_blk.pos.block_col !== want_blk.pos.block_col ||
            got_blk.pos.frame_last !== want_blk.pos.frame_last)
          log_mismatch("block mismatch", want_blk, got_blk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
  endtask

  task automatic send_run(input int unsigned count, input pixel_mode_e mode);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mode));
  endtask

  task automatic drain_blocks();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_blocks();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned b);
    write_reg(REG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(REG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
    write_reg(REG_BLOCK_SIZE, b[CFG_DATA_W-1:0]);
  endtask

  // height and block size left at their reset values on a narrow frame
  task automatic test_reset_values();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(8));
    send_run(64, PIX_RANDOM);
  endtask

  task automatic test_pixel_extremes();
    logic [7:0] ramp [8] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254, 8'h55, 8'hAA};
    logic [7:0] floor_cases [12] = '{8'd255, 8'd255, 8'd255, 8'd255,
                                     8'd0, 8'd0, 8'd0, 8'd3,
                                     8'd255, 8'd255, 8'd255, 8'd254};
    set_frame(4, 2, 1);
    foreach (ramp[i]) send_pixel(ramp[i]);
    set_frame(2, 2, 2);
    foreach (floor_cases[i]) send_pixel(floor_cases[i]);
  endtask

  // zero registers act as 1, oversize block acts as 16
  task automatic test_size_clamping();
    set_frame(0, 0, 0);
    send_run(3, PIX_RANDOM);
    set_frame(16, 16, 31);
    send_run(256, PIX_WHITE);
  endtask

  task automatic test_block_over_frame();
    set_frame(3, 5, 4);
    send_run(30, PIX_RANDOM);
  endtask

  task automatic test_restart_on_write();
    set_frame(6, 4, 2);
    send_run(8, PIX_RANDOM);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(1023)));
    send_run(24, PIX_RANDOM);
  endtask

  task automatic test_backpressure();
    set_frame(64, 4, 1);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_run(64, PIX_RANDOM);
    drain_blocks();
    send_run(16, PIX_RANDOM);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_sel  [4] = '{0, 49, 0, 19};
    int unsigned stall_sel [4] = '{0, 0, 49, 19};
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned b;
    int unsigned frame_px;
    int unsigned count;
    int unsigned pick;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_sel[p];
      stall_pct <= stall_sel[p];
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 70) w = $urandom_range(1, 16);
        else if (pick < 80) w = 0;
        else if (pick < 90) w = $urandom_range(41, 512);
        else w = $urandom_range(513, 1023);
        pick = $urandom_range(99);
        if (pick < 80) h = $urandom_range(1, 12);
        else if (pick < 90) h = 0;
        else h = $urandom_range(513, 1023);
        pick = $urandom_range(99);
        if (pick < 55) b = $urandom_range(1, 4);
        else if (pick < 80) b = $urandom_range(5, 16);
        else if (pick < 90) b = $urandom_range(17, 31);
        else if (pick < 95) b = 0;
        else b = $urandom_range(1023);
        set_frame(w, h, b);
        frame_px = eff_dim(w, MAX_W) * eff_dim(h, HEIGHT_LIMIT);
        if (frame_px <= 400) count = frame_px * $urandom_range(1, 2);
        else count = $urandom_range(40, 250);
        if ($urandom_range(3) == 0) count = $urandom_range(1, count);
        if (count > PHASE_BEATS - sent) count = PHASE_BEATS - sent;
        send_run(count, pixel_mode_e'($urandom_range(2)));
        sent += count;
      end
    end
  endtask

  initial begin
    frame_width_q  = RST_FRAME_WIDTH;
    frame_height_q = RST_FRAME_HEIGHT;
    block_size_q   = RST_BLOCK_SIZE;
    restart_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_pixel_extremes();
    test_size_clamping();
    test_block_over_frame();
    test_restart_on_write();
    test_backpressure();
    test_random_traffic();
    drain_blocks();
    if (mismatch_count == 0 && expected_blocks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
